/* rtl/hlls_pkg.sv */
// ---------------------------------------------------------------------------
// hlls_pkg: shared types and constants
// Command and status bundles between the sketch controller and datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package hlls_pkg;

  localparam logic [32:0] FoldMod = 33'h0_FFFF_FFFB;
  localparam logic [31:0] MixA    = 32'h85EB_CA6B;
  localparam logic [31:0] MixB    = 32'hC2B2_AE35;

  localparam int unsigned EstW  = 42;
  localparam int unsigned RankW = 5;

  typedef struct packed {
    logic clr_wr;
    logic fold_en;
    logic key_end;
    logic mix1;
    logic mix2;
    logic fin;
    logic lza;
    logic lzb;
    logic upd;
    logic div_start;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_done;
  } status_t;

endpackage

`default_nettype wire

/* rtl/hlls_div.sv */
// ---------------------------------------------------------------------------
// hlls_div: restoring divider
// Unsigned quotient, one bit per cycle, MSB first.
// ---------------------------------------------------------------------------
`default_nettype none

module hlls_div #(
  parameter int unsigned NumW = 47,
  parameter int unsigned DenW = 34
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [DenW-1:0] den_i,
  output logic                 done_o,
  output logic [NumW-1:0]      quo_o
);

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [DenW-1:0] den_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [DenW:0]   shifted;
  logic            ge;

  always_comb begin
    shifted = {rem_q, quo_q[NumW-1]};
    ge      = shifted >= {1'b0, den_q};
    quo_d   = quo_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? DenW'(shifted - {1'b0, den_q}) : shifted[DenW-1:0];
      quo_d = {quo_q[NumW-2:0], ge};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

/* rtl/hlls_dp.sv */
// ---------------------------------------------------------------------------
// hlls_dp: sketch datapath
// Character fold, hash finalizer, rank search, bucket store, harmonic sum.
// ---------------------------------------------------------------------------
`default_nettype none

module hlls_dp #(
  parameter int unsigned IndexBits = 6,
  parameter logic [31:0] Alpha     = 32'd3045131813
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire hlls_pkg::cmd_t            cmd_i,
  output hlls_pkg::status_t              status_o,
  input  wire logic [6:0]                char_i,
  output logic [hlls_pkg::EstW-1:0]      est_o,
  output logic [IndexBits-1:0]           idx_o,
  output logic [hlls_pkg::RankW-1:0]     rank_o
);

  localparam int unsigned BucketCount = 1 << IndexBits;
  localparam int unsigned HsW         = IndexBits + 33;
  localparam int unsigned NumW        = 41 + IndexBits;
  localparam int unsigned DenW        = HsW - (IndexBits - 1);
  localparam int unsigned RankW       = hlls_pkg::RankW;

  logic [31:0]              fold_sum_q;
  logic [1:0]               grp_q;
  logic [32:0]              sum_raw;
  logic [31:0]              sum_mod;
  logic [31:0]              h0_q, h1_q, h2_q, h3;
  logic [31:0]              w_q;
  logic [IndexBits-1:0]     idx_q;
  logic [IndexBits-1:0]     clr_cnt_q;
  logic [3:0]               nz_q;
  logic [2:0]               lz8 [4];
  logic [2:0]               lz8_q [4];
  logic [5:0]               lz;
  logic [RankW-1:0]         rank_q;
  logic [RankW-1:0]         rd_q;
  logic [HsW-1:0]           hs_q;
  logic [HsW-1:0]           hs_next;
  logic [RankW-1:0]         mem_q [BucketCount];
  logic                     div_done;
  logic [NumW-1:0]          quo;
  logic [hlls_pkg::EstW-1:0] est_q;
  logic [IndexBits-1:0]      idx_out_q;
  logic [RankW-1:0]          rank_out_q;

  always_comb begin
    sum_raw = {1'b0, fold_sum_q} + (33'(char_i) << {grp_q, 3'b000});
    sum_mod = (sum_raw >= hlls_pkg::FoldMod) ? 32'(sum_raw - hlls_pkg::FoldMod)
                                             : sum_raw[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_sum_q <= '0;
      grp_q      <= '0;
      clr_cnt_q  <= '0;
      hs_q       <= HsW'(1) << (IndexBits + 32);
    end else begin
      if (cmd_i.clr_wr) begin
        clr_cnt_q <= clr_cnt_q + IndexBits'(1);
      end
      if (cmd_i.fold_en) begin
        if (cmd_i.key_end) begin
          fold_sum_q <= '0;
          grp_q      <= '0;
        end else begin
          fold_sum_q <= sum_mod;
          grp_q      <= grp_q + 2'd1;
        end
      end
      if (cmd_i.upd && (rd_q < rank_q)) begin
        hs_q <= hs_next;
      end
    end
  end

  always_comb begin
    hs_next = hs_q - (HsW'(1) << (6'd32 - 6'(rd_q))) + (HsW'(1) << (6'd32 - 6'(rank_q)));
    h3      = h2_q ^ (h2_q >> 16);
    for (int b = 0; b < 4; b++) begin
      lz8[b] = 3'd0;
      for (int i = 0; i < 8; i++) begin
        if (w_q[8*b + i]) begin
          lz8[b] = 3'(7 - i);
        end
      end
    end
    lz      = 6'd32;
    for (int b = 0; b < 4; b++) begin
      if (nz_q[b]) begin
        lz = 6'(8 * (3 - b)) + 6'(lz8_q[b]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.key_end) begin
      h0_q <= sum_mod;
    end
    if (cmd_i.mix1) begin
      h1_q <= 32'((h0_q ^ (h0_q >> 16)) * hlls_pkg::MixA);
    end
    if (cmd_i.mix2) begin
      h2_q <= 32'((h1_q ^ (h1_q >> 13)) * hlls_pkg::MixB);
    end
    if (cmd_i.fin) begin
      idx_q <= h3[IndexBits-1:0];
      w_q   <= h3 >> IndexBits;
    end
    if (cmd_i.lza) begin
      rd_q <= mem_q[idx_q];
      for (int b = 0; b < 4; b++) begin
        nz_q[b]  <= |w_q[8*b +: 8];
        lz8_q[b] <= lz8[b];
      end
    end
    if (cmd_i.lzb) begin
      rank_q <= RankW'(lz - 6'(IndexBits) + 6'd1);
    end
    if (cmd_i.clr_wr) begin
      mem_q[clr_cnt_q] <= '0;
    end else if (cmd_i.upd && (rd_q < rank_q)) begin
      mem_q[idx_q] <= rank_q;
    end
    if (cmd_i.load_out) begin
      est_q      <= quo[hlls_pkg::EstW-1:0];
      idx_out_q  <= idx_q;
      rank_out_q <= rank_q;
    end
  end

  hlls_div #(
    .NumW(NumW),
    .DenW(DenW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (NumW'(Alpha) << (IndexBits + 9)),
    .den_i  (hs_q[HsW-1:IndexBits-1]),
    .done_o (div_done),
    .quo_o  (quo)
  );

  assign status_o.clr_last = &clr_cnt_q;
  assign status_o.div_done = div_done;
  assign est_o             = est_q;
  assign idx_o             = idx_out_q;
  assign rank_o            = rank_out_q;

endmodule

`default_nettype wire

/* rtl/hlls_ctrl.sv */
// ---------------------------------------------------------------------------
// hlls_ctrl: sketch controller
// Sequences clearing, per-key hashing, bucket update and estimate division.
// ---------------------------------------------------------------------------
`default_nettype none

module hlls_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_last_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output hlls_pkg::cmd_t         cmd_o,
  input  wire hlls_pkg::status_t status_i
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MIX1, S_MIX2, S_FIN, S_LZA, S_LZB, S_UPD, S_DIVGO, S_DIV, S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   load;

  always_comb begin
    load = (state_q == S_OUT) && (!out_valid_q || out_ready_i);
    cmd_o           = '0;
    cmd_o.clr_wr    = state_q == S_CLEAR;
    cmd_o.fold_en   = (state_q == S_IDLE) && in_valid_i;
    cmd_o.key_end   = (state_q == S_IDLE) && in_valid_i && in_last_i;
    cmd_o.mix1      = state_q == S_MIX1;
    cmd_o.mix2      = state_q == S_MIX2;
    cmd_o.fin       = state_q == S_FIN;
    cmd_o.lza       = state_q == S_LZA;
    cmd_o.lzb       = state_q == S_LZB;
    cmd_o.upd       = state_q == S_UPD;
    cmd_o.div_start = state_q == S_DIVGO;
    cmd_o.load_out  = load;

    state_d = state_q;
    case (state_q)
      S_CLEAR: if (status_i.clr_last) begin
        state_d = S_IDLE;
      end
      S_IDLE:  if (in_valid_i && in_last_i) begin
        state_d = S_MIX1;
      end
      S_MIX1:  state_d = S_MIX2;
      S_MIX2:  state_d = S_FIN;
      S_FIN:   state_d = S_LZA;
      S_LZA:   state_d = S_LZB;
      S_LZB:   state_d = S_UPD;
      S_UPD:   state_d = S_DIVGO;
      S_DIVGO: state_d = S_DIV;
      S_DIV:   if (status_i.div_done) begin
        state_d = S_OUT;
      end
      S_OUT:   if (load) begin
        state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase

    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

/* rtl/hyperloglog_string_sketch_unit.sv */
// ---------------------------------------------------------------------------
// hyperloglog_string_sketch_unit: streaming cardinality sketch over keys
// Key characters come in on the slave stream, one per request, tlast on the
// final character. Each key end yields one result request on the master
// stream with the running cardinality estimate, the bucket and the rank.
//
// Non-final characters leave the intake open. A final character closes it
// while the two finalizer multiplies, rank search, bucket read-modify-write
// and the one-bit-per-cycle estimate divider run, and the intake opens
// again once that key's result is loaded into the output register.
// After reset a clearing pass zeroes the bucket store, one entry a cycle, with
// s_axis_tready_o low.
// The result sits in an output register; while the receiver stalls the
// block keeps taking characters and hashing the next key, and holds only
// when that key's result is ready and the register is still full.
// ---------------------------------------------------------------------------
`default_nettype none

module hyperloglog_string_sketch_unit #(
  parameter int unsigned INDEX_BITS = 6
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [6:0] char_byte
  input  wire logic       s_axis_tlast_i,   // last_char
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  // [41:0] estimate_q8, [41+P:42] bucket_index, [46+P:42+P] key_rank
  output logic [((47 + INDEX_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata_o
);

  localparam int unsigned BucketCount = 1 << INDEX_BITS;
  localparam int unsigned OutW        = ((47 + INDEX_BITS + 7) / 8) * 8;
  localparam int unsigned FieldW      = 47 + INDEX_BITS;
  localparam logic [63:0] AlphaGen    =
    ((64'd7213 * 64'(BucketCount)) << 32) / (64'd10000 * 64'(BucketCount) + 64'd10790);
  localparam logic [31:0] Alpha =
    (BucketCount == 16) ? 32'd2890512990 :
    (BucketCount == 32) ? 32'd2993592205 :
    (BucketCount == 64) ? 32'd3045131813 : AlphaGen[31:0];

  hlls_pkg::cmd_t             cmd;
  hlls_pkg::status_t          status;
  logic [hlls_pkg::EstW-1:0]  est;
  logic [INDEX_BITS-1:0]      idx;
  logic [hlls_pkg::RankW-1:0] rank;

  hlls_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_last_i  (s_axis_tlast_i),
    .in_ready_o (s_axis_tready_o),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  hlls_dp #(
    .IndexBits(INDEX_BITS),
    .Alpha    (Alpha)
  ) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .status_o(status),
    .char_i  (s_axis_tdata_i[6:0]),
    .est_o   (est),
    .idx_o   (idx),
    .rank_o  (rank)
  );

  assign m_axis_tdata_o = OutW'({rank, idx, est});

`ifndef SYNTHESIS
  a_key_end_stops_intake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i |=> !s_axis_tready_o)
    else $error("intake open after key end");

  a_clear_blocks_intake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr_wr |-> !s_axis_tready_o)
    else $error("intake open during clearing pass");

  a_rank_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[FieldW-1:42+INDEX_BITS] != '0) &&
      (m_axis_tdata_o[FieldW-1:42+INDEX_BITS] <= 5'(33 - INDEX_BITS)))
    else $error("rank out of range");
`endif

endmodule

`default_nettype wire

/* test/testbench.sv */
// ---------------------------------------------------------------------------
// testbench: self-checking bench for hyperloglog_string_sketch_unit
// Streams key characters with random gaps and stalls, predicts each key's
// bucket, rank and estimate in a local model, and compares every result.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PBits = 6;
  localparam int unsigned Buckets = 1 << PBits;
  localparam int unsigned OutW = ((47 + PBits + 7) / 8) * 8;
  localparam longint unsigned Alpha = 64'd3045131813;
  localparam longint unsigned CycleLimit = 64'd1500000;

  typedef struct packed {
    logic [4:0]  rank;
    logic [5:0]  bucket;
    logic [41:0] estimate;
  } sketch_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [7:0] s_axis_tdata_i = '0;
  logic s_axis_tlast_i = 1'b0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [OutW-1:0] m_axis_tdata_o;

  hyperloglog_string_sketch_unit #(.INDEX_BITS(PBits)) dut (.*);

  always #4 clk_i = ~clk_i;

  logic [31:0] acc_sum, acc_pow;
  logic [1:0] acc_pos;
  logic [4:0] bucket_max [Buckets];
  longint unsigned hsum;
  sketch_res_t pending_q [$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit recv_hold = 1'b0;
  longint unsigned cycles = 0;

  function automatic logic [31:0] scramble(logic [31:0] h);
    h ^= h >> 16;
    h = h * 32'h85EBCA6B;
    h ^= h >> 13;
    h = h * 32'hC2B2AE35;
    h ^= h >> 16;
    return h;
  endfunction

  task automatic predict_char(logic [6:0] c, logic lst);
    logic [31:0] h, w;
    int unsigned idx, rk, lz;
    sketch_res_t r;
    acc_sum = 32'((64'(acc_sum) + 64'(c) * 64'(acc_pow)) % 64'd4294967291);
    if (acc_pos == 2'd3) begin
      acc_pow = 32'd1;
      acc_pos = 2'd0;
    end else begin
      acc_pow = 32'((64'(acc_pow) * 64'd256) % 64'd4294967291);
      acc_pos = acc_pos + 2'd1;
    end
    if (!lst) return;
    h = scramble(acc_sum);
    acc_sum = '0;
    acc_pow = 32'd1;
    acc_pos = '0;
    idx = h & (Buckets - 1);
    w = h >> PBits;
    lz = 0;
    while (lz < 32 && !w[31 - lz]) lz++;
    rk = (w == 0) ? 33 - PBits : lz - PBits + 1;
    if (bucket_max[idx] < rk) begin
      hsum = hsum - (64'd1 << (32 - bucket_max[idx])) + (64'd1 << (32 - rk));
      bucket_max[idx] = 5'(rk);
    end
    r.estimate = 42'((Alpha << (PBits + 9)) / (hsum >> (PBits - 1)));
    r.bucket = 6'(idx);
    r.rank = 5'(rk);
    pending_q = {pending_q, r};
  endtask

  task automatic send_char(logic [6:0] c, logic lst);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {1'b0, c};
    s_axis_tlast_i <= lst;
    predict_char(c, lst);
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic send_key(int unsigned len, bit full_range);
    for (int unsigned i = 0; i < len; i++)
      send_char(full_range ? 7'($urandom) : 7'($urandom_range(97, 122)), i == len - 1);
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("testbench NOT OK");
      $finish;
    end
    m_axis_tready_i <= !recv_hold &&
                       !(recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      sketch_res_t got;
      got = sketch_res_t'(m_axis_tdata_o[52:0]);
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        sketch_res_t exp_r;
        exp_r = pending_q.pop_front();
        if (got !== exp_r) begin
          $display("%0t: expected est=%0d bkt=%0d rank=%0d, actual est=%0d bkt=%0d rank=%0d",
                   $time, exp_r.estimate, exp_r.bucket, exp_r.rank,
                   got.estimate, got.bucket, got.rank);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    send_char(7'h00, 1'b1);
    send_char(7'h7F, 1'b1);
    send_key(4, 1);
    send_key(5, 1);
    send_key(8, 1);
    for (int i = 0; i < 4; i++) send_char(7'h7F, i == 3);
    for (int i = 0; i < 9; i++) send_char(7'h00, i == 8);
    send_char(7'h55, 1'b0);
    send_char(7'h2A, 1'b1);
  endtask

  task automatic test_random(int unsigned chars);
    int unsigned n;
    n = 0;
    while (n < chars) begin
      int unsigned len;
      len = ($urandom_range(9) == 0) ? $urandom_range(20, 12) : $urandom_range(6, 1);
      send_key(len, $urandom_range(1));
      n += len;
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        recv_hold = 1'b1;
        repeat (400) @(posedge clk_i);
        recv_hold = 1'b0;
      end
      test_random(60);
    join
  endtask

  initial begin
    acc_sum = '0;
    acc_pow = 32'd1;
    acc_pos = '0;
    foreach (bucket_max[i]) bucket_max[i] = '0;
    hsum = 64'(Buckets) << 32;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    send_idle_pct = 38;
    recv_idle_pct = 45;
    test_random(560);
    send_idle_pct = 45;
    recv_idle_pct = 38;
    test_random(540);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random(540);
    s_axis_tvalid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule
